FILE: rtl/core/sqsg_pkg.sv
// Shared types and constants for the slide/gate step sequencer.
package sqsg_pkg;

  // Fixed field widths
  localparam int unsigned PITCH_W      = 16;
  localparam int unsigned REG_W        = 20;
  localparam int unsigned COEFF_W      = 16;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned INDEX_W      = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned IN_TDATA_W   = 24;
  localparam int unsigned IN_TUSER_W   = 2;
  localparam int unsigned OUT_TDATA_W  = 24;

  // Parameter defaults
  localparam int unsigned STEPS_DEFAULT       = 16;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 20;

  // Reset values
  localparam logic [PITCH_W-1:0] PITCH_RESET       = 16'd7040;
  localparam logic [REG_W-1:0]   STEP_PERIOD_RESET = 20'd6000;
  localparam logic [REG_W-1:0]   GATE_POINT_RESET  = 20'd4000;
  localparam logic [COEFF_W-1:0] SLIDE_COEFF_RESET = 16'd68;

  // Rounding constant for the Q16.16 glide product
  localparam logic [31:0] GLIDE_HALF = 32'd32768;

  typedef enum logic [1:0] {
    KIND_INACTIVE = 2'd0,
    KIND_ACTIVE   = 2'd1,
    KIND_HOLD     = 2'd2,
    KIND_SLIDE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD = 2'd0,
    CFG_GATE_POINT  = 2'd1,
    CFG_SLIDE_COEFF = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    kind_t              kind;
    logic [PITCH_W-1:0] pitch;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{kind: KIND_INACTIVE, pitch: PITCH_RESET};

endpackage

FILE: rtl/core/step_sequencer_slide_gate_core.sv
// Step sequencer with slide and gate: one sample tick or command per transaction.
// The block takes one input transaction per clock cycle and returns exactly one result
// transaction for it in the next cycle through an output register; back-to-back transactions
// sustain one per cycle, stalled only by m_tready. The step table sits in a memory with a
// single registered read port that runs two steps ahead of the current position; the entries
// at the current and next positions, and at positions 0 and 1, are kept in registers so a
// step can advance on every tick and a stop can restart at step 0 at once. Table entries
// never written read as inactive at 440 Hz; there is no clearing pass. The critical path is
// the 16x16 glide multiply followed by the rounding add and the pitch select.
module step_sequencer_slide_gate_core #(
  parameter int unsigned STEPS       = sqsg_pkg::STEPS_DEFAULT,
  parameter int unsigned COUNT_WIDTH = sqsg_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // tuser: action[1:0]
  input  logic [sqsg_pkg::IN_TUSER_W-1:0]      s_tuser,
  // tdata: step_addr[3:0], step_kind[5:4], step_pitch[21:6], zero pad[23:22]
  input  logic [sqsg_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // tdata: pitch[15:0], note_on[16], note_off[17], advanced[18], step_index[22:19],
  //        is_running[23]
  output logic [sqsg_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sqsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sqsg_pkg::REG_W-1:0]           cfg_data
);

  localparam int unsigned PW   = $clog2(STEPS);
  localparam int unsigned CMPW = (COUNT_WIDTH > sqsg_pkg::REG_W) ? COUNT_WIDTH
                                                                 : sqsg_pkg::REG_W;
  localparam int unsigned SAW  = (PW > sqsg_pkg::ADDR_W) ? PW + 1 : sqsg_pkg::ADDR_W + 1;

  function automatic logic [PW-1:0] idx_inc(input logic [PW-1:0] i);
    logic [PW-1:0] r;
    if (i == PW'(STEPS - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  // Configuration registers
  logic [sqsg_pkg::REG_W-1:0]   step_period;
  logic [sqsg_pkg::REG_W-1:0]   gate_point;
  logic [sqsg_pkg::COEFF_W-1:0] slide_coeff;

  // Sequencer state
  logic                         running, running_next;
  logic [COUNT_WIDTH-1:0]       sample_count, sample_count_next;
  logic [PW-1:0]                step_pos, step_pos_next;
  logic [sqsg_pkg::PITCH_W-1:0] cur_pitch, cur_pitch_next;

  // Entry shadows: current step, next step, step 0, step 1
  sqsg_pkg::entry_t cur_ent, cur_ent_next;
  sqsg_pkg::entry_t nxt_ent, nxt_ent_next;
  sqsg_pkg::entry_t ent0, ent1;

  // Step table memory with lookahead read
  sqsg_pkg::entry_t mem [STEPS];
  logic [STEPS-1:0] mem_vld;
  sqsg_pkg::entry_t rd_q;
  sqsg_pkg::entry_t fwd_data_q;
  logic             fwd_q;
  logic             vld_q;
  sqsg_pkg::entry_t pf_ent;
  logic [PW-1:0]    raddr;

  // Input decode
  logic                           in_fire;
  sqsg_pkg::action_t              action;
  logic [sqsg_pkg::ADDR_W-1:0]    step_addr;
  sqsg_pkg::kind_t                step_kind;
  logic [sqsg_pkg::PITCH_W-1:0]   step_pitch;
  logic                           wr_en;
  logic [PW-1:0]                  wr_idx;
  sqsg_pkg::entry_t               wr_ent;

  // Step arithmetic
  logic [PW-1:0]                  next_pos;
  logic [COUNT_WIDTH-1:0]         count_inc;
  logic                           at_gate;
  logic                           at_period;
  logic                           slide_up;
  logic [sqsg_pkg::PITCH_W-1:0]   glide_diff;
  logic [31:0]                    glide_prod;
  logic [sqsg_pkg::PITCH_W-1:0]   glide_delta;
  logic [sqsg_pkg::PITCH_W-1:0]   glide_pitch;

  // Result flags
  logic note_on, note_off, advanced;

  assign in_fire    = s_tvalid && s_tready;
  assign s_tready   = !m_tvalid || m_tready;
  assign cfg_ready  = 1'b1;

  assign action     = sqsg_pkg::action_t'(s_tuser);
  assign step_addr  = s_tdata[3:0];
  assign step_kind  = sqsg_pkg::kind_t'(s_tdata[5:4]);
  assign step_pitch = s_tdata[21:6];

  assign wr_en  = in_fire && (action == sqsg_pkg::ACT_WRITE) &&
                  (SAW'(step_addr) < SAW'(STEPS));
  assign wr_idx = PW'(step_addr);
  assign wr_ent = '{kind: step_kind, pitch: step_pitch};

  // Lookahead entry two steps past the current position
  assign pf_ent = fwd_q ? fwd_data_q : (vld_q ? rd_q : sqsg_pkg::ENTRY_RESET);

  // Glide toward the current step pitch with round-half-up magnitude
  assign next_pos    = idx_inc(step_pos);
  assign count_inc   = (&sample_count) ? sample_count : sample_count + 1'b1;
  assign at_gate     = (CMPW'(count_inc) == CMPW'(gate_point));
  assign at_period   = (CMPW'(count_inc) == CMPW'(step_period));
  assign slide_up    = (cur_ent.pitch >= cur_pitch);
  assign glide_diff  = slide_up ? cur_ent.pitch - cur_pitch : cur_pitch - cur_ent.pitch;
  assign glide_prod  = 32'(glide_diff) * 32'(slide_coeff);
  assign glide_delta = 16'((33'(glide_prod) + 33'(sqsg_pkg::GLIDE_HALF)) >> 16);
  assign glide_pitch = slide_up ? cur_pitch + glide_delta : cur_pitch - glide_delta;

  // Next state and result flags for one transaction
  always_comb begin
    running_next      = running;
    sample_count_next = sample_count;
    step_pos_next     = step_pos;
    cur_pitch_next    = cur_pitch;
    cur_ent_next      = cur_ent;
    nxt_ent_next      = nxt_ent;
    note_on           = 1'b0;
    note_off          = 1'b0;
    advanced          = 1'b0;
    case (action)
      sqsg_pkg::ACT_TICK: begin
        if (running) begin
          sample_count_next = count_inc;
          if (at_gate && (nxt_ent.kind != sqsg_pkg::KIND_HOLD) &&
              (nxt_ent.kind != sqsg_pkg::KIND_SLIDE)) begin
            note_off = 1'b1;
          end
          if (cur_ent.kind == sqsg_pkg::KIND_SLIDE) begin
            cur_pitch_next = glide_pitch;
          end
          if (at_period) begin
            sample_count_next = '0;
            step_pos_next     = next_pos;
            advanced          = 1'b1;
            cur_ent_next      = nxt_ent;
            nxt_ent_next      = pf_ent;
            if (nxt_ent.kind == sqsg_pkg::KIND_ACTIVE) begin
              cur_pitch_next = nxt_ent.pitch;
              note_on        = 1'b1;
            end
          end
        end
      end
      sqsg_pkg::ACT_WRITE: begin
        if (wr_en && (wr_idx == step_pos)) begin
          cur_ent_next = wr_ent;
        end
        if (wr_en && (wr_idx == next_pos)) begin
          nxt_ent_next = wr_ent;
        end
      end
      sqsg_pkg::ACT_START: begin
        running_next = 1'b1;
      end
      sqsg_pkg::ACT_STOP: begin
        if (running) begin
          running_next      = 1'b0;
          step_pos_next     = '0;
          sample_count_next = '0;
          note_off          = 1'b1;
          cur_ent_next      = ent0;
          nxt_ent_next      = ent1;
        end
      end
      default: begin
        running_next = running;
      end
    endcase
  end

  // Prefetch address follows the position this transaction leads to
  assign raddr = in_fire ? idx_inc(idx_inc(step_pos_next)) : idx_inc(idx_inc(step_pos));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= sqsg_pkg::STEP_PERIOD_RESET;
      gate_point  <= sqsg_pkg::GATE_POINT_RESET;
      slide_coeff <= sqsg_pkg::SLIDE_COEFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (sqsg_pkg::cfg_idx_t'(cfg_index))
        sqsg_pkg::CFG_STEP_PERIOD: step_period <= cfg_data;
        sqsg_pkg::CFG_GATE_POINT:  gate_point  <= cfg_data;
        sqsg_pkg::CFG_SLIDE_COEFF: slide_coeff <= cfg_data[sqsg_pkg::COEFF_W-1:0];
        default: begin
          step_period <= step_period;
        end
      endcase
    end
  end

  // Sequencer state and entry shadows
  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      sample_count <= '0;
      step_pos     <= '0;
      cur_pitch    <= sqsg_pkg::PITCH_RESET;
      cur_ent      <= sqsg_pkg::ENTRY_RESET;
      nxt_ent      <= sqsg_pkg::ENTRY_RESET;
      ent0         <= sqsg_pkg::ENTRY_RESET;
      ent1         <= sqsg_pkg::ENTRY_RESET;
    end else if (in_fire) begin
      running      <= running_next;
      sample_count <= sample_count_next;
      step_pos     <= step_pos_next;
      cur_pitch    <= cur_pitch_next;
      cur_ent      <= cur_ent_next;
      nxt_ent      <= nxt_ent_next;
      if (wr_en && (wr_idx == PW'(0))) begin
        ent0 <= wr_ent;
      end
      if (wr_en && (wr_idx == PW'(1))) begin
        ent1 <= wr_ent;
      end
    end
  end

  // Table write and registered lookahead read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    rd_q       <= mem[raddr];
    fwd_data_q <= wr_ent;
  end

  // Written-entry flags and read forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      fwd_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        mem_vld[wr_idx] <= 1'b1;
      end
      fwd_q <= wr_en && (wr_idx == raddr);
      vld_q <= mem_vld[raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= {running_next, sqsg_pkg::INDEX_W'(step_pos_next), advanced, note_off,
                  note_on, cur_pitch_next};
    end
  end

endmodule
